FILE: hdl/assert_macros.svh
// assertion macros shared by the reassembler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLKD(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

FILE: hdl/hcipr_pkg.sv
// types, codes and header helpers for the hci packet reassembler
package hcipr_pkg;

   localparam logic [1:0] KIND_EVENT    = 2'd0;
   localparam logic [1:0] KIND_ACL      = 2'd1;
   localparam logic [1:0] KIND_SCO      = 2'd2;
   localparam logic [1:0] KIND_RESERVED = 2'd3;

   localparam int NUM_KINDS = 3;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic [7:0] data;
      logic       frame_start;
      logic       frame_end;
      logic       header_error;
   } hcipr_result_type;

   // header length in bytes per kind
   function automatic logic [2:0] hdr_size(input logic [1:0] kind);
      logic [2:0] size;
      case (kind)
         KIND_EVENT: size = 3'd2;
         KIND_ACL:   size = 3'd4;
         default:    size = 3'd3;
      endcase
      return size;
   endfunction

   // payload length contribution of the header byte at position idx
   function automatic logic [16:0] len_part(input logic [1:0] kind,
                                            input logic [1:0] idx,
                                            input logic [7:0] b);
      logic [16:0] part;
      part = '0;
      if (kind == KIND_EVENT && idx == 2'd1) part = {9'd0, b};
      if (kind == KIND_ACL   && idx == 2'd2) part = {9'd0, b};
      if (kind == KIND_ACL   && idx == 2'd3) part = {1'b0, b, 8'd0};
      if (kind == KIND_SCO   && idx == 2'd2) part = {9'd0, b};
      return part;
   endfunction

endpackage

FILE: hdl/hcipr_engine.sv
// per-kind reassembly contexts and the single-pass word classifier
module hcipr_engine
   import hcipr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  logic [1:0]       kind,
   input  logic [7:0]       data_byte,
   input  logic [15:0]      bytes_left,
   output hcipr_result_type result
);

   logic [NUM_KINDS-1:0] active_ff, active_in;
   logic [1:0]           hidx_ff [NUM_KINDS];
   logic [1:0]           hidx_in [NUM_KINDS];
   logic [16:0]          rem_ff  [NUM_KINDS];
   logic [16:0]          rem_in  [NUM_KINDS];
   logic                 drop_ff, drop_in;

   logic        chunk_end;
   logic        cur_active;
   logic [1:0]  cur_hidx;
   logic [16:0] cur_rem;
   logic [2:0]  hs;
   logic [1:0]  hs_last;
   logic [1:0]  nxt_hidx;
   logic [17:0] r_sum;
   logic [17:0] r_dec;

   always_comb begin
      chunk_end = (bytes_left <= 16'd1);
      hs        = hdr_size(kind);
      hs_last   = hs[1:0] - 2'd1;
      case (kind)
         KIND_EVENT: begin
            cur_active = active_ff[0];
            cur_hidx   = hidx_ff[0];
            cur_rem    = rem_ff[0];
         end
         KIND_ACL: begin
            cur_active = active_ff[1];
            cur_hidx   = hidx_ff[1];
            cur_rem    = rem_ff[1];
         end
         KIND_SCO: begin
            cur_active = active_ff[2];
            cur_hidx   = hidx_ff[2];
            cur_rem    = rem_ff[2];
         end
         default: begin
            cur_active = 1'b0;
            cur_hidx   = 2'd0;
            cur_rem    = '0;
         end
      endcase

      // header byte index and remaining count for an active frame
      nxt_hidx = cur_hidx;
      r_sum    = {1'b0, cur_rem};
      if (cur_hidx < hs_last) begin
         nxt_hidx = cur_hidx + 2'd1;
         r_sum    = {1'b0, cur_rem} + {1'b0, len_part(kind, nxt_hidx, data_byte)};
      end
      r_dec = (r_sum == 18'd0) ? 18'd0 : r_sum - 18'd1;

      active_in = active_ff;
      hidx_in   = hidx_ff;
      rem_in    = rem_ff;
      drop_in   = drop_ff;
      result    = '0;
      result.kind = kind;
      result.data = data_byte;

      if (fire) begin
         if (drop_ff) begin
            if (chunk_end) drop_in = 1'b0;
         end else if (kind != KIND_RESERVED) begin
            result.valid = 1'b1;
            if (!cur_active) begin
               if (bytes_left < {13'd0, hs}) begin
                  // header would straddle the chunk end
                  result.header_error = 1'b1;
                  result.data         = 8'd0;
                  if (!chunk_end) drop_in = 1'b1;
               end else begin
                  result.frame_start = 1'b1;
                  active_in[kind]    = 1'b1;
                  hidx_in[kind]      = 2'd0;
                  rem_in[kind]       = {15'd0, hs_last};
               end
            end else begin
               rem_in[kind]  = r_dec[16:0];
               hidx_in[kind] = nxt_hidx;
               if (r_dec[16:0] == 17'd0) begin
                  result.frame_end = 1'b1;
                  active_in[kind]  = 1'b0;
                  hidx_in[kind]    = 2'd0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         drop_ff   <= 1'b0;
         for (int k = 0; k < NUM_KINDS; k++) begin
            hidx_ff[k] <= 2'd0;
            rem_ff[k]  <= '0;
         end
      end else begin
         active_ff <= active_in;
         drop_ff   <= drop_in;
         hidx_ff   <= hidx_in;
         rem_ff    <= rem_in;
      end
   end

endmodule

FILE: hdl/hci_packet_reassembler_core.sv
// hci packet reassembler: per-kind framing of a received byte stream, one word per
// cycle while the receiver keeps up; each req word lands in an input register, is
// classified against its kind's context (event, acl or sco) in one pass, and the
// result sits in an output register until taken; a new word is taken every cycle
// unless rsp_ready holds the output, so sustained rate is one word per clock, and
// rsp_valid rises once the word has passed the input and output registers; words of
// kind 3 and words dropped after a header error are consumed without a rsp word
module hci_packet_reassembler_core
   import hcipr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_pkt_kind,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_bytes_left_in_chunk,
   // response side
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_out_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_start,
   output logic        rsp_frame_end,
   output logic        rsp_header_error
);

`include "assert_macros.svh"

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_kind_ff;
   logic [7:0]  in_byte_ff;
   logic [15:0] in_left_ff;

   // output register
   hcipr_result_type res_ff, res_in;
   hcipr_result_type eng_res;

   logic fire;
   logic req_take;

   // the held word moves on once the output slot is free or being emptied
   assign fire      = in_valid_ff && (!res_ff.valid || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign req_take  = req_valid && req_ready;

   hcipr_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .kind       (in_kind_ff),
      .data_byte  (in_byte_ff),
      .bytes_left (in_left_ff),
      .result     (eng_res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) in_valid_in = 1'b1;
      else if (fire) in_valid_in = 1'b0;

      res_in = res_ff;
      if (fire) res_in = eng_res;
      else if (rsp_ready) res_in.valid = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         res_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         res_ff      <= res_in;
      end
   end

   // payload of the input register, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= req_pkt_kind;
         in_byte_ff <= req_data_byte;
         in_left_ff <= req_bytes_left_in_chunk;
      end
   end

   assign rsp_valid        = res_ff.valid;
   assign rsp_out_kind     = res_ff.kind;
   assign rsp_out_byte     = res_ff.data;
   assign rsp_frame_start  = res_ff.frame_start;
   assign rsp_frame_end    = res_ff.frame_end;
   assign rsp_header_error = res_ff.header_error;

   // a header error forwards nothing and never marks a frame boundary
   `ASSERT_CLKD(a_err_clean, clock, reset,
      rsp_valid && rsp_header_error |-> !rsp_frame_start && !rsp_frame_end && rsp_out_byte == 8'd0)
   // the first word of a frame can never also close it
   `ASSERT_CLKD(a_start_not_end, clock, reset, rsp_valid |-> !(rsp_frame_start && rsp_frame_end))
   // a held word is not lost while the output is stalled
   `ASSERT_CLKD(a_hold_input, clock, reset, in_valid_ff && !fire |=> in_valid_ff)

endmodule

FILE: tb/tb_top.sv
// testbench for the hci packet reassembler core, checking per-kind framing word by word
`timescale 1ns / 100ps

module tb_top;
   import hcipr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 10;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       sof;
      logic       eof;
      logic       hdr_err;
   } frame_word_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_pkt_kind = KIND_EVENT;
   logic [7:0]  req_data_byte = '0;
   logic [15:0] req_bytes_left_in_chunk = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_out_kind;
   logic [7:0]  rsp_out_byte;
   logic        rsp_frame_start;
   logic        rsp_frame_end;
   logic        rsp_header_error;

   // predicted reassembly context, one per kind
   bit          ctx_active  [0:2] = '{default: 1'b0};
   logic [1:0]  ctx_hdr_pos [0:2] = '{default: '0};
   logic [16:0] ctx_remain  [0:2] = '{default: '0};
   bit          dropping_chunk = 1'b0;

   frame_word_type expected_words [$];

   int idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   int cycle_count = 0;
   int words_sent = 0;
   int results_due = 0;
   int words_checked = 0;
   int frames_closed = 0;
   int header_errors = 0;
   int mismatch_count = 0;

   hci_packet_reassembler_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int header_bytes(input logic [1:0] kind);
      case (kind)
         KIND_EVENT: return 2;
         KIND_ACL:   return 4;
         default:    return 3;
      endcase
   endfunction

   // what a header byte adds to the payload length, by kind and position
   function automatic logic [16:0] length_field(input logic [1:0] kind, input logic [1:0] pos,
                                                input logic [7:0] b);
      case ({kind, pos})
         {KIND_EVENT, 2'd1}, {KIND_ACL, 2'd2}, {KIND_SCO, 2'd2}: return {9'd0, b};
         {KIND_ACL, 2'd3}:                                       return {1'b0, b, 8'd0};
         default:                                                return '0;
      endcase
   endfunction

   // advances the predicted contexts by one word; returns 1 when a result word is due
   function automatic bit predict_reassembly(input logic [1:0] kind, input logic [7:0] data,
                                             input logic [15:0] left, output frame_word_type w);
      int          hlen;
      logic [16:0] remain;
      bit          chunk_end;
      w = '0;
      w.kind = kind;
      chunk_end = (left <= 16'd1);
      if (dropping_chunk) begin
         if (chunk_end) dropping_chunk = 1'b0;
         return 1'b0;
      end
      if (kind == KIND_RESERVED) return 1'b0;
      hlen = header_bytes(kind);
      if (!ctx_active[kind]) begin
         // header must fit in what is left of the chunk
         if (int'(left) < hlen) begin
            if (!chunk_end) dropping_chunk = 1'b1;
            w.hdr_err = 1'b1;
            return 1'b1;
         end
         ctx_active[kind] = 1'b1;
         ctx_hdr_pos[kind] = '0;
         ctx_remain[kind] = 17'(hlen - 1);
         w.data = data;
         w.sof = 1'b1;
         return 1'b1;
      end
      remain = ctx_remain[kind];
      if (int'(ctx_hdr_pos[kind]) < hlen - 1) begin
         ctx_hdr_pos[kind] = ctx_hdr_pos[kind] + 2'd1;
         remain = remain + length_field(kind, ctx_hdr_pos[kind], data);
      end
      if (remain != '0) remain = remain - 17'd1;
      ctx_remain[kind] = remain;
      w.data = data;
      if (remain == '0) begin
         w.eof = 1'b1;
         ctx_active[kind] = 1'b0;
         ctx_hdr_pos[kind] = '0;
      end
      return 1'b1;
   endfunction

   // next byte of a well-formed stream for this kind, short payloads mostly
   function automatic logic [7:0] craft_byte(input logic [1:0] kind);
      int pos;
      int roll;
      if (!ctx_active[kind] || int'(ctx_hdr_pos[kind]) >= header_bytes(kind) - 1)
         return 8'($urandom_range(0, 255));
      pos = ctx_hdr_pos[kind] + 1;
      roll = $urandom_range(0, 99);
      if (kind == KIND_ACL && pos == 3) return (roll < 97) ? 8'd0 : 8'd1;
      if (kind != KIND_EVENT && pos == 1) return 8'($urandom_range(0, 255));
      if (roll < 70) return 8'($urandom_range(0, 12));
      if (roll < 95) return 8'($urandom_range(13, 64));
      return 8'($urandom_range(65, 255));
   endfunction

   function automatic void report_mismatch(input string what, input frame_word_type want,
                                           input frame_word_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("mismatch, %s: expected kind %0d byte %h start %b end %b err %b,",
                  what, want.kind, want.data, want.sof, want.eof, want.hdr_err);
         $display("   got kind %0d byte %h start %b end %b err %b",
                  got.kind, got.data, got.sof, got.eof, got.hdr_err);
      end
   endfunction

   task automatic send_word(input logic [1:0] kind, input logic [7:0] data,
                            input logic [15:0] left);
      frame_word_type w;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pkt_kind <= kind;
      req_data_byte <= data;
      req_bytes_left_in_chunk <= left;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      if (predict_reassembly(kind, data, left, w)) begin
         expected_words.push_back(w);
         results_due++;
      end
   endtask

   // sender goes quiet until every predicted word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic send_clean_chunk(input logic [1:0] kind, input int len);
      for (int i = 0; i < len; i++) send_word(kind, craft_byte(kind), 16'(len - i));
   endtask

   // mixed kinds, reserved kind and erratic chunk counts, zero included
   task automatic send_noisy_chunk(input int len);
      logic [15:0] left;
      for (int i = 0; i < len; i++) begin
         left = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) : 16'(len - i - 1);
         send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), left);
      end
   endtask

   // zero payloads on event and sco, acl frame split over two chunks
   task automatic test_frame_basics();
      idle_pct = 12;
      stall_pct = 12;
      send_word(KIND_EVENT, 8'h0E, 16'd2);
      send_word(KIND_EVENT, 8'h00, 16'd1);
      send_word(KIND_SCO, 8'hFF, 16'd3);
      send_word(KIND_SCO, 8'h00, 16'd2);
      send_word(KIND_SCO, 8'h00, 16'd1);
      send_word(KIND_ACL, 8'hFF, 16'hFFFF);
      send_word(KIND_ACL, 8'h00, 16'hFFFE);
      send_word(KIND_ACL, 8'h01, 16'd2);
      send_word(KIND_ACL, 8'h00, 16'd1);
      send_word(KIND_ACL, 8'hA5, 16'd1);
      wait_drained();
   endtask

   // header not fitting, dropping to chunk end, zero count, reserved kind
   task automatic test_header_errors();
      send_word(KIND_ACL, 8'h11, 16'd3);
      send_word(KIND_EVENT, 8'h22, 16'd2);
      send_word(KIND_RESERVED, 8'h33, 16'd1);
      send_word(KIND_EVENT, 8'h44, 16'd1);
      send_word(KIND_SCO, 8'h55, 16'd0);
      send_word(KIND_RESERVED, 8'hFF, 16'hFFFF);
      send_word(KIND_RESERVED, 8'h00, 16'd1);
      wait_drained();
   endtask

   // long receiver hold while a 62-byte event frame is offered back to back
   task automatic test_output_hold();
      idle_pct = 0;
      stall_pct = 0;
      hold_cycles = 150;
      send_word(KIND_EVENT, 8'h0E, 16'd62);
      send_word(KIND_EVENT, 8'd60, 16'd61);
      for (int i = 0; i < 60; i++) send_word(KIND_EVENT, 8'($urandom_range(0, 255)), 16'(60 - i));
      wait_drained();
   endtask

   task automatic test_random_traffic(input int idle, input int stall, input int quota);
      int target;
      int len;
      idle_pct = idle;
      stall_pct = stall;
      target = results_due + quota;
      while (results_due < target) begin
         if ($urandom_range(0, 99) < 80) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300)
                                               : $urandom_range(1, 24);
            send_clean_chunk(2'($urandom_range(0, 2)), len);
         end else begin
            send_noisy_chunk($urandom_range(1, 12));
         end
      end
      wait_drained();
   endtask

   // receiver: random stalls, or a counted hold when one is requested
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      frame_word_type got;
      frame_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_out_kind, rsp_out_byte, rsp_frame_start, rsp_frame_end, rsp_header_error};
         words_checked++;
         if (got.eof) frames_closed++;
         if (got.hdr_err) header_errors++;
         if (expected_words.size() == 0) begin
            report_mismatch("no word pending", '0, got);
         end else begin
            want = expected_words.pop_front();
            if (got !== want) report_mismatch("wrong field", want, got);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timed out after %0d cycles, %0d words still pending",
               cycle_count, expected_words.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_frame_basics();
      test_header_errors();
      test_output_hold();
      test_random_traffic(0, 0, 150);
      test_random_traffic(76, 0, 150);
      test_random_traffic(0, 76, 150);
      test_random_traffic(12, 12, 150);
      repeat (DRAIN_CYCLES) @(posedge clock);
      mismatch_count += expected_words.size();
      $display("covered %0d input words over event, acl, sco and reserved kinds with idling",
               words_sent);
      $display("and stalls; %0d words checked, %0d frames closed, %0d header errors, %0d mismatches",
               words_checked, frames_closed, header_errors, mismatch_count);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
